// ----- rtl/core/lru_pkg.sv -----
// shared types and constants for the lru page replacement stack
package lru_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
	localparam int FRAMES_W   = 4;
	localparam int POS_W      = 3;
	localparam int COUNT_W    = 16;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
		logic                 last_reference;
	} lru_req_t;

	typedef struct packed {
		logic               hit;
		logic [POS_W-1:0]   hit_position;
		logic [COUNT_W-1:0] miss_count;
		logic               final_res;
	} lru_res_t;

	typedef struct packed {
		logic step;
		logic cfg_write;
	} lru_cmd_t;

	typedef struct packed {
		logic last_ref;
	} lru_status_t;

endpackage

// ----- rtl/core/lru_ctrl.sv -----
// controller for the lru page replacement stack
module lru_ctrl
	import lru_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        cfg_we,
	input  lru_status_t status,
	output lru_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	localparam logic ST_EMPTY  = 1'b0;
	localparam logic ST_STRING = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	// one reference per cycle, so never held off
	assign busy          = 1'b0;
	assign cmd.step      = start & ~busy;
	assign cmd.cfg_write = cfg_we;
	assign done          = done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (cmd.step && !status.last_ref) state_d = ST_STRING;
			end
			ST_STRING: begin
				if (cmd.step && status.last_ref) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.step;
		end
	end

endmodule

// ----- rtl/core/lru_dpath.sv -----
// datapath: recency stack, compare, shift, miss counter and result register
module lru_dpath
	import lru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lru_cmd_t            cmd,
	input  lru_req_t            request,
	input  logic [FRAMES_W-1:0] cfg_wdata,
	output lru_status_t         status,
	output lru_res_t            result
);

	logic [PAGE_BITS-1:0] stack_q [MAX_FRAMES];
	logic [PAGE_BITS-1:0] stack_d [MAX_FRAMES];
	logic [OCC_W-1:0]     occ_q;
	logic [COUNT_W-1:0]   miss_q;
	logic [FRAMES_W-1:0]  frames_q;
	lru_res_t             result_q;

	logic [OCC_W-1:0]     frames_eff;
	logic [OCC_W-1:0]     occ_eff;
	logic [OCC_W-1:0]     occ_next;
	logic [OCC_W-1:0]     top;
	logic [MAX_FRAMES-1:0] match;
	logic                 found;
	logic [IDX_W-1:0]     pos;
	logic [COUNT_W-1:0]   miss_next;

	assign status.last_ref = request.last_reference;
	assign result          = result_q;

	always_comb begin
		if (frames_q == '0)
			frames_eff = OCC_W'(1);
		else if (32'(frames_q) > MAX_FRAMES)
			frames_eff = OCC_W'(MAX_FRAMES);
		else
			frames_eff = OCC_W'(frames_q);
		occ_eff = (occ_q < frames_eff) ? occ_q : frames_eff;
	end

	// parallel compare against valid entries, lowest position wins
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = (OCC_W'(i) < occ_eff) && (stack_q[i] == request.page_number);
		end
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				found = 1'b1;
				pos   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		top = (occ_eff < frames_eff) ? occ_eff : frames_eff - OCC_W'(1);
		if (found) begin
			occ_next  = occ_eff;
			miss_next = miss_q;
		end else begin
			occ_next  = (occ_eff < frames_eff) ? occ_eff + OCC_W'(1) : occ_eff;
			miss_next = (miss_q == '1) ? miss_q : miss_q + COUNT_W'(1);
		end
		stack_d[0] = request.page_number;
		for (int i = 1; i < MAX_FRAMES; i++) begin
			if (found)
				stack_d[i] = (OCC_W'(i) <= OCC_W'(pos)) ? stack_q[i-1] : stack_q[i];
			else
				stack_d[i] = (OCC_W'(i) <= top) ? stack_q[i-1] : stack_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			miss_q   <= '0;
			frames_q <= FRAMES_W'(3);
		end else begin
			if (cmd.cfg_write) frames_q <= cfg_wdata;
			if (cmd.step) begin
				occ_q  <= request.last_reference ? '0 : occ_next;
				miss_q <= request.last_reference ? '0 : miss_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			for (int i = 0; i < MAX_FRAMES; i++) stack_q[i] <= stack_d[i];
			result_q.hit          <= found;
			result_q.hit_position <= POS_W'(pos);
			result_q.miss_count   <= miss_next;
			result_q.final_res    <= request.last_reference;
		end
	end

endmodule

// ----- rtl/core/lru_page_replacement.sv -----
// top level of the lru page replacement recency stack
//
// usage
// - a reference (page number and last flag) is transferred at a rising edge
//   with start high and busy low; busy never rises, so one reference may be
//   transferred every cycle
// - each reference gives exactly one result: hit, hit position, running miss
//   count and the final flag, shown on result for one cycle with done high,
//   in the cycle after the reference was transferred
// - throughput is one reference per cycle: all stack entries are compared in
//   parallel and the shift of the recency stack happens in the same edge
// - the receiver cannot stall; results must be taken as they appear
// - frames_in_use is written through cfg_we / cfg_wdata while no reference is
//   in flight; 0 acts as one frame, values above the stack depth as the depth
// - reset clears the occupancy, the miss counter and the done strobe and sets
//   frames_in_use to 3; stack contents stay unknown until written
// - after a reference marked last, the stack empties and the counter clears
module lru_page_replacement
	import lru_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lru_req_t            request,
	output logic                done,
	output lru_res_t            result,
	input  logic                cfg_we,
	input  logic [FRAMES_W-1:0] cfg_wdata
);

	lru_cmd_t    cmd;
	lru_status_t status;

	// sequencing: accept, update and result strobe
	lru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// recency stack with compare, shift and counters
	lru_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.request   (request),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.result    (result)
	);

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the lru page replacement recency stack
`timescale 1ns / 100ps

module testbench;
	import lru_pkg::*;

	// run length and limits
	localparam int RANDOM_REFS  = 500;
	localparam int CYCLE_LIMIT  = 60000;
	localparam int KEEP_FRAMES  = -1;
	localparam int DRAIN_CYCLES = 4;

	// one row of the directed table; pinned rows carry a hand-typed result
	typedef struct {
		int        frames_set;
		lru_req_t  req;
		bit        pinned;
		lru_res_t  want;
	} ref_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	lru_req_t            request;
	logic                done;
	lru_res_t            result;
	logic                cfg_we;
	logic [FRAMES_W-1:0] cfg_wdata;

	// side band driven with each transfer: hand-typed result for pinned rows
	logic     row_pinned;
	lru_res_t row_value;

	// shadow of the block: recency stack, occupancy, miss counter, frame count
	logic [PAGE_BITS-1:0] shadow_stack [MAX_FRAMES];
	int                   shadow_occ;
	logic [COUNT_W-1:0]   shadow_misses;
	logic [FRAMES_W-1:0]  shadow_frames;

	lru_res_t  outcome_q [$];
	ref_row_t  directed_rows [$];
	int        accepted_refs;
	int        mismatches;
	int        cycle_count;
	int        random_refs;
	int        setting_changes;

	lru_page_replacement dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// works out the outcome of one reference and moves the shadow state on
	function automatic lru_res_t lookup_page(input lru_req_t r);
		lru_res_t res;
		int       frames;
		int       occ;
		int       pos;
		int       top;
		bit       found;
		frames = (shadow_frames == 0) ? 1 :
			(shadow_frames > MAX_FRAMES) ? MAX_FRAMES : int'(shadow_frames);
		// a lowered frame count throws away the entries beyond it
		occ   = (shadow_occ < frames) ? shadow_occ : frames;
		pos   = 0;
		found = 1'b0;
		for (int i = 0; i < occ; i++) begin
			if (!found && shadow_stack[i] == r.page_number) begin
				pos   = i;
				found = 1'b1;
			end
		end
		// on a hit only the entries above the match shift; on a miss the oldest may drop
		top = found ? pos : ((occ < frames) ? occ : frames - 1);
		for (int i = top; i > 0; i--)
			shadow_stack[i] = shadow_stack[i-1];
		shadow_stack[0] = r.page_number;
		if (!found) begin
			if (occ < frames)
				occ++;
			if (shadow_misses != '1)
				shadow_misses++;
		end
		shadow_occ       = occ;
		res.hit          = found;
		res.hit_position = pos[POS_W-1:0];
		res.miss_count   = shadow_misses;
		res.final_res    = r.last_reference;
		// end of a reference string: stack empties, counter clears
		if (r.last_reference) begin
			shadow_occ    = 0;
			shadow_misses = '0;
		end
		return res;
	endfunction

	function automatic void check_field(input string field, input logic [15:0] want_v,
		input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
			mismatches++;
		end
	endfunction

	// result checking first, then the transfer of a new reference, so that a
	// result never meets the outcome pushed at the same edge
	always @(posedge clk) begin : result_check
		lru_res_t want;
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (outcome_q.size() == 0) begin
					$error("result with no reference outstanding");
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					check_field("done", 16'd1, {15'd0, done});
					check_field("hit", {15'd0, want.hit}, {15'd0, result.hit});
					check_field("hit_position", {13'd0, want.hit_position},
						{13'd0, result.hit_position});
					check_field("miss_count", want.miss_count, result.miss_count);
					check_field("final_res", {15'd0, want.final_res}, {15'd0, result.final_res});
				end
			end
			if (cfg_we)
				shadow_frames = cfg_wdata;
			if (start && !busy) begin
				want = lookup_page(request);
				if (row_pinned)
					want = row_value;
				outcome_q.push_back(want);
				accepted_refs++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// drives one reference after a gap and returns at the falling edge after its transfer;
	// start is left high so that a back-to-back reference needs no second assignment
	task automatic send_ref(input lru_req_t req, input int gap, input bit pinned,
		input lru_res_t pin);
		int seen;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seen = accepted_refs;
		start      <= 1'b1;
		request    <= req;
		row_pinned <= pinned;
		row_value  <= pin;
		do @(negedge clk); while (accepted_refs == seen);
	endtask

	// frame count is only changed with nothing in flight
	task automatic set_frames(input logic [FRAMES_W-1:0] value);
		start <= 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		setting_changes++;
	endtask

	task automatic add_row(input int frames_set, input logic [15:0] page, input bit last,
		input bit pinned, input bit hit, input int pos, input int misses);
		ref_row_t row;
		row.frames_set          = frames_set;
		row.req.page_number     = page;
		row.req.last_reference  = last;
		row.pinned              = pinned;
		row.want.hit            = hit;
		row.want.hit_position   = pos[POS_W-1:0];
		row.want.miss_count     = misses[COUNT_W-1:0];
		row.want.final_res      = last;
		directed_rows.push_back(row);
	endtask

	initial begin : stimulus
		lru_req_t             req;
		logic [PAGE_BITS-1:0] base;
		int                   span;
		int                   len;
		bit                   burst;
		bit                   close_string;
		logic [FRAMES_W-1:0]  frames;

		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		row_pinned = 1'b0;
		row_value  = '0;
		shadow_occ    = 0;
		shadow_misses = '0;
		shadow_frames = 4'd3;
		foreach (shadow_stack[i])
			shadow_stack[i] = '0;
		accepted_refs   = 0;
		mismatches      = 0;
		cycle_count     = 0;
		random_refs     = 0;
		setting_changes = 0;

		// three frames out of reset: extremes of the page field, hits, evictions
		add_row(KEEP_FRAMES, 16'h0000, 0, 1, 0, 0, 1);
		add_row(KEEP_FRAMES, 16'hFFFF, 0, 1, 0, 0, 2);
		add_row(KEEP_FRAMES, 16'hFFFF, 0, 1, 1, 0, 2);
		add_row(KEEP_FRAMES, 16'h0000, 0, 1, 1, 1, 2);
		add_row(KEEP_FRAMES, 16'h1234, 0, 1, 0, 0, 3);
		add_row(KEEP_FRAMES, 16'h5678, 0, 1, 0, 0, 4);
		add_row(KEEP_FRAMES, 16'hFFFF, 0, 1, 0, 0, 5);
		add_row(KEEP_FRAMES, 16'h1234, 1, 1, 1, 2, 5);
		add_row(KEEP_FRAMES, 16'h1234, 0, 1, 0, 0, 1);
		// frame count of zero behaves as a single frame, set mid-string
		add_row(0,           16'h1234, 0, 1, 1, 0, 1);
		add_row(KEEP_FRAMES, 16'h5555, 0, 1, 0, 0, 2);
		add_row(KEEP_FRAMES, 16'h1234, 1, 1, 0, 0, 3);
		// full depth, then a hit in the deepest position
		add_row(8,           16'h0001, 0, 0, 0, 0, 0);
		for (int p = 2; p <= 8; p++)
			add_row(KEEP_FRAMES, p[15:0], 0, 0, 0, 0, 0);
		add_row(KEEP_FRAMES, 16'h0001, 0, 1, 1, 7, 8);
		// lowering the frame count truncates the stack
		add_row(2,           16'h0008, 0, 0, 0, 0, 0);
		add_row(KEEP_FRAMES, 16'h0007, 1, 0, 0, 0, 0);
		// count above the stack depth behaves as the full depth
		add_row(15,          16'hFFFF, 0, 0, 0, 0, 0);
		add_row(KEEP_FRAMES, 16'h0000, 1, 0, 0, 0, 0);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].frames_set != KEEP_FRAMES)
				set_frames(directed_rows[i].frames_set[FRAMES_W-1:0]);
			send_ref(directed_rows[i].req, $urandom_range(0, 15), directed_rows[i].pinned,
				directed_rows[i].want);
		end

		// random strings over a small page window so that hits are common
		while (random_refs < RANDOM_REFS) begin
			case ($urandom_range(0, 5))
				0: frames = 4'd0;
				1: frames = 4'd1;
				2: frames = 4'd8;
				3: frames = 4'd15;
				default: frames = FRAMES_W'($urandom_range(0, 15));
			endcase
			set_frames(frames);
			burst        = ($urandom_range(0, 3) == 0);
			close_string = ($urandom_range(0, 3) != 0);
			len          = $urandom_range(1, 40);
			base         = PAGE_BITS'($urandom());
			span         = $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0)
					req.page_number = PAGE_BITS'($urandom());
				else
					req.page_number = base + PAGE_BITS'($urandom_range(0, span));
				// mostly well-formed strings; a stray early end now and then
				req.last_reference = (k == len - 1) ? close_string :
					($urandom_range(0, 49) == 0);
				send_ref(req, burst ? 0 : $urandom_range(0, 15), 1'b0, '0);
				random_refs++;
			end
		end

		start <= 1'b0;
		while (outcome_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d directed rows and %0d random references",
			directed_rows.size(), random_refs);
		$display("%0d frame count writes, %0d references checked in total",
			setting_changes, accepted_refs);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/lru_pkg.sv
rtl/core/lru_ctrl.sv
rtl/core/lru_dpath.sv
rtl/core/lru_page_replacement.sv
dv/testbench.sv
